[rtl/core/charge_bypass_policy_assert.svh]
// assertion macros for the charge bypass policy block
// expects clk and rst_n in the scope where a macro is used
`ifndef CHARGE_BYPASS_POLICY_ASSERT_SVH
`define CHARGE_BYPASS_POLICY_ASSERT_SVH

// same-cycle implication
`define CBP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("charge_bypass_policy: same-cycle check failed");

// next-cycle implication
`define CBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("charge_bypass_policy: next-cycle check failed");

`endif

[rtl/core/cbp_pkg.sv]
// shared types and constants for the charge bypass policy block
// no dependencies
`default_nettype none

package cbp_pkg;

  localparam int TEMP_W  = 12;
  localparam int CAP_W   = 7;
  localparam int EN_W    = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [2:0] {
    CAUSE_NONE   = 3'd0,
    CAUSE_ALWAYS = 3'd1,
    CAUSE_TEMP   = 3'd2,
    CAUSE_CAP    = 3'd3,
    CAUSE_GAME   = 3'd4
  } cause_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE     = 3'd0,
    REG_TEMP_OPEN  = 3'd1,
    REG_TEMP_CLOSE = 3'd2,
    REG_CAP_OPEN   = 3'd3,
    REG_CAP_CLOSE  = 3'd4,
    REG_FAST_CAP   = 3'd5,
    REG_FAST_TEMP  = 3'd6
  } reg_idx_t;

  localparam int EN_MASTER = 0;
  localparam int EN_ALWAYS = 1;
  localparam int EN_TEMP   = 2;
  localparam int EN_CAP    = 3;
  localparam int EN_FAST   = 4;

endpackage

`default_nettype wire

[rtl/core/charge_bypass_policy.sv]
// charge bypass policy: bypass and idle fast-charge decision per check tick
// depends on cbp_pkg and charge_bypass_policy_assert.svh
//
// channel  dir  handshake              payload
// in_      in   in_tvalid/in_tready    in_tdata  temperature, capacity, charging, game
// out_     out  out_tvalid/out_tready  out_tdata bypass_on, fast_charge_on, bypass_cause
// cfg_     in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// one tick per cycle sustained while out_tready is high; a stall at out_ holds it
// the policy update runs between the input register and the result register
// an empty input register takes a tick even while a result waits at out_
// rst_n clears flags, cause and all configuration registers; cfg_ready is always high
`default_nettype none

`include "charge_bypass_policy_assert.svh"

module charge_bypass_policy
  import cbp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [11:0] temperature, [18:12] capacity, [19] charging, [20] game_foreground
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [0] bypass_on, [1] fast_charge_on, [4:2] bypass_cause
  output logic [OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration
  logic [EN_W-1:0]          enable_r;
  logic signed [TEMP_W-1:0] temp_open_r, temp_close_r, fast_temp_r;
  logic [CAP_W-1:0]         cap_open_r, cap_close_r, fast_cap_r;

  // input stage
  logic                     in_v_r;
  logic signed [TEMP_W-1:0] temp_r;
  logic [CAP_W-1:0]         cap_r;
  logic                     chg_r, game_r;

  // policy state
  logic   bypass_r, bypass_nxt;
  logic   fast_r, fast_nxt;
  cause_t cause_r, cause_nxt;

  // result stage
  logic out_v_r;
  logic move;

  assign cfg_ready  = 1'b1;
  assign move       = in_v_r && (!out_v_r || out_tready);
  assign in_tready  = !in_v_r || move;
  assign out_tvalid = out_v_r;
  assign out_tdata  = {3'b000, cause_r, fast_r, bypass_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= '0;
      temp_open_r  <= '0;
      temp_close_r <= '0;
      cap_open_r   <= '0;
      cap_close_r  <= '0;
      fast_cap_r   <= '0;
      fast_temp_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ENABLE:     enable_r     <= cfg_data[EN_W-1:0];
        REG_TEMP_OPEN:  temp_open_r  <= cfg_data[TEMP_W-1:0];
        REG_TEMP_CLOSE: temp_close_r <= cfg_data[TEMP_W-1:0];
        REG_CAP_OPEN:   cap_open_r   <= cfg_data[CAP_W-1:0];
        REG_CAP_CLOSE:  cap_close_r  <= cfg_data[CAP_W-1:0];
        REG_FAST_CAP:   fast_cap_r   <= cfg_data[CAP_W-1:0];
        REG_FAST_TEMP:  fast_temp_r  <= cfg_data[TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_v_r <= 1'b1;
    end else if (move) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      temp_r <= in_tdata[11:0];
      cap_r  <= in_tdata[18:12];
      chg_r  <= in_tdata[19];
      game_r <= in_tdata[20];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      bypass_r <= 1'b0;
      fast_r   <= 1'b0;
      cause_r  <= CAUSE_NONE;
    end else begin
      if (move) begin
        out_v_r  <= 1'b1;
        bypass_r <= bypass_nxt;
        fast_r   <= fast_nxt;
        cause_r  <= cause_nxt;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // priority rules; done marks a rule that ends the tick
  always_comb begin
    logic done;
    done       = 1'b0;
    bypass_nxt = bypass_r;
    fast_nxt   = fast_r;
    cause_nxt  = cause_r;

    if (enable_r[EN_MASTER]) begin
      if (enable_r[EN_ALWAYS] && !bypass_nxt) begin
        bypass_nxt = 1'b1;
        cause_nxt  = CAUSE_ALWAYS;
      end else if (!enable_r[EN_ALWAYS] && cause_nxt == CAUSE_ALWAYS) begin
        bypass_nxt = 1'b0;
        cause_nxt  = CAUSE_NONE;
      end else if (cause_nxt == CAUSE_ALWAYS) begin
        done = 1'b1;
      end
    end

    if (!done && !chg_r) begin
      if (bypass_nxt || fast_nxt) begin
        bypass_nxt = 1'b0;
        cause_nxt  = CAUSE_NONE;
        fast_nxt   = 1'b0;
      end
      done = 1'b1;
    end

    if (!done && (!bypass_nxt || cause_nxt == CAUSE_GAME)) begin
      if (game_r) begin
        cause_nxt  = CAUSE_GAME;
        bypass_nxt = 1'b1;
        done       = 1'b1;
      end else if (bypass_nxt && cause_nxt == CAUSE_GAME) begin
        bypass_nxt = 1'b0;
        cause_nxt  = CAUSE_NONE;
      end
    end

    if (!done) begin
      if (enable_r[EN_TEMP]) begin
        if (cause_nxt == CAUSE_NONE && temp_r >= temp_open_r) begin
          fast_nxt   = 1'b0;
          cause_nxt  = CAUSE_TEMP;
          bypass_nxt = 1'b1;
          done       = 1'b1;
        end else if (cause_nxt == CAUSE_TEMP && temp_r < temp_close_r) begin
          bypass_nxt = 1'b0;
          cause_nxt  = CAUSE_NONE;
        end
      end else if (cause_nxt == CAUSE_TEMP) begin
        bypass_nxt = 1'b0;
        cause_nxt  = CAUSE_NONE;
      end
    end

    if (!done) begin
      if (enable_r[EN_CAP]) begin
        if (cause_nxt == CAUSE_NONE && cap_r >= cap_open_r) begin
          fast_nxt   = 1'b0;
          cause_nxt  = CAUSE_CAP;
          bypass_nxt = 1'b1;
          done       = 1'b1;
        end else if (cause_nxt == CAUSE_CAP && cap_r < cap_close_r) begin
          bypass_nxt = 1'b0;
          cause_nxt  = CAUSE_NONE;
        end
      end else if (cause_nxt == CAUSE_CAP) begin
        bypass_nxt = 1'b0;
        cause_nxt  = CAUSE_NONE;
      end
    end

    if (!done) begin
      if (enable_r[EN_FAST]) begin
        if (!bypass_nxt && !fast_nxt && cap_r < fast_cap_r && temp_r < fast_temp_r) begin
          fast_nxt = 1'b1;
        end else if (fast_nxt && (cap_r >= fast_cap_r || temp_r >= fast_temp_r)) begin
          fast_nxt = 1'b0;
        end
      end else begin
        fast_nxt = 1'b0;
      end
    end
  end

  `CBP_ASSERT_NOW(a_flag_matches_cause, 1'b1, bypass_r == (cause_r != CAUSE_NONE))
  `CBP_ASSERT_NEXT(a_move_fills_result, move, out_v_r)
  `CBP_ASSERT_NEXT(a_state_held_when_idle, !move,
                   $stable(bypass_r) && $stable(fast_r) && $stable(cause_r))

endmodule

`default_nettype wire

[bench/tb.sv]
// self-checking bench for charge_bypass_policy: directed ticks, then random phases
// under several idle and stall patterns, checked against an in-bench policy predictor
// depends on cbp_pkg and the charge_bypass_policy rtl
module tb;
  import cbp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES = 8;
  localparam int HALF_TICKS = 100;

  typedef struct packed {
    logic                    game;
    logic                    charging;
    logic [CAP_W-1:0]        cap;
    logic signed [TEMP_W-1:0] temp;
  } tick_t;

  typedef struct packed {
    cause_t cause;
    logic   fast;
    logic   bypass;
  } flags_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  charge_bypass_policy dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of configuration and state
  logic [EN_W-1:0] en_bits;
  logic signed [TEMP_W-1:0] t_open, t_close, f_temp;
  logic [CAP_W-1:0] c_open, c_close, f_cap;
  logic bypass_st, fast_st;
  cause_t cause_st;

  tick_t pending_ticks[$];
  flags_t expected_flags[$];
  logic tick_taken = 1'b0;
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int walk_temp, walk_cap;
  logic game_on;

  function automatic void drop_bypass();
    bypass_st = 1'b0;
    cause_st = CAUSE_NONE;
  endfunction

  function automatic void advance_policy(input tick_t tk);
    logic signed [TEMP_W-1:0] t;
    logic [CAP_W-1:0] c;
    t = tk.temp;
    c = tk.cap;
    if (en_bits[EN_MASTER]) begin
      if (en_bits[EN_ALWAYS] && !bypass_st) begin
        bypass_st = 1'b1;
        cause_st = CAUSE_ALWAYS;
      end else if (!en_bits[EN_ALWAYS] && cause_st == CAUSE_ALWAYS) begin
        drop_bypass();
      end else if (cause_st == CAUSE_ALWAYS) begin
        return;
      end
    end
    if (!tk.charging) begin
      if (bypass_st || fast_st) begin
        drop_bypass();
        fast_st = 1'b0;
      end
      return;
    end
    if (!bypass_st || cause_st == CAUSE_GAME) begin
      if (tk.game) begin
        cause_st = CAUSE_GAME;
        bypass_st = 1'b1;
        return;
      end else if (bypass_st && cause_st == CAUSE_GAME) begin
        drop_bypass();
      end
    end
    if (en_bits[EN_TEMP]) begin
      if (cause_st == CAUSE_NONE && t >= t_open) begin
        fast_st = 1'b0;
        cause_st = CAUSE_TEMP;
        bypass_st = 1'b1;
        return;
      end else if (cause_st == CAUSE_TEMP && t < t_close) begin
        drop_bypass();
      end
    end else if (cause_st == CAUSE_TEMP) begin
      drop_bypass();
    end
    if (en_bits[EN_CAP]) begin
      if (cause_st == CAUSE_NONE && c >= c_open) begin
        fast_st = 1'b0;
        cause_st = CAUSE_CAP;
        bypass_st = 1'b1;
        return;
      end else if (cause_st == CAUSE_CAP && c < c_close) begin
        drop_bypass();
      end
    end else if (cause_st == CAUSE_CAP) begin
      drop_bypass();
    end
    if (en_bits[EN_FAST]) begin
      if (!bypass_st && !fast_st && c < f_cap && t < f_temp)
        fast_st = 1'b1;
      else if (fast_st && (c >= f_cap || t >= f_temp))
        fast_st = 1'b0;
    end else if (fast_st) begin
      fast_st = 1'b0;
    end
  endfunction

  function automatic logic [TEMP_W-1:0] pick_temp();
    case ($urandom_range(5))
      0: return TEMP_W'(-400);
      1: return TEMP_W'(1500);
      2: return TEMP_W'($urandom);
      default: return TEMP_W'(int'($urandom_range(1900)) - 400);
    endcase
  endfunction

  function automatic logic [CAP_W-1:0] pick_cap();
    case ($urandom_range(5))
      0: return CAP_W'(0);
      1: return CAP_W'(100);
      2: return CAP_W'(127);
      default: return CAP_W'($urandom_range(100));
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ENABLE:     en_bits = val[EN_W-1:0];
      REG_TEMP_OPEN:  t_open = val[TEMP_W-1:0];
      REG_TEMP_CLOSE: t_close = val[TEMP_W-1:0];
      REG_CAP_OPEN:   c_open = val[CAP_W-1:0];
      REG_CAP_CLOSE:  c_close = val[CAP_W-1:0];
      REG_FAST_CAP:   f_cap = val[CAP_W-1:0];
      REG_FAST_TEMP:  f_temp = val[TEMP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_tick(input int t, input int c, input logic chg, input logic game);
    tick_t tk;
    tk.temp = TEMP_W'(t);
    tk.cap = CAP_W'(c);
    tk.charging = chg;
    tk.game = game;
    pending_ticks.push_back(tk);
  endtask

  // wait until the block has drained every transfer
  task automatic settle();
    while (pending_ticks.size() != 0 || in_tvalid || expected_flags.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // sender
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || tick_taken)) begin
      if (pending_ticks.size() != 0 && $urandom_range(99) >= gap_pct) begin
        in_tdata <= {3'b000, pending_ticks.pop_front()};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    tick_taken = 1'b0;
  end

  // receiver
  always @(negedge clk) begin
    if (rst_n)
      out_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (hold_left > 0)
      hold_left <= hold_left - 1;
  end

  // result check, then prediction for the accepted tick
  always @(posedge clk) begin
    flags_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = flags_t'(out_tdata[4:0]);
        if (expected_flags.size() == 0) begin
          $display("%0t unexpected result bypass=%0d fast=%0d cause=%0d",
                   $time, got.bypass, got.fast, got.cause);
          fail_count++;
        end else begin
          want = expected_flags.pop_front();
          if (got.bypass !== want.bypass || got.fast !== want.fast ||
              got.cause !== want.cause) begin
            $display("%0t mismatch expected b=%0d f=%0d c=%0d, got b=%0d f=%0d c=%0d",
                     $time, want.bypass, want.fast, want.cause,
                     got.bypass, got.fast, got.cause);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        advance_policy(tick_t'(in_tdata[20:0]));
        want.bypass = bypass_st;
        want.fast = fast_st;
        want.cause = cause_st;
        expected_flags.push_back(want);
        tick_taken = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** charge_bypass_policy: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [EN_W-1:0] en;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    en_bits = '0;
    t_open = '0;
    t_close = '0;
    c_open = '0;
    c_close = '0;
    f_cap = '0;
    f_temp = '0;
    bypass_st = 1'b0;
    fast_st = 1'b0;
    cause_st = CAUSE_NONE;
    game_on = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // always bypass: just set then cleared, set, then held while not charging
    write_reg(REG_ENABLE, 12'h01F);
    write_reg(REG_TEMP_OPEN, 12'(450));
    write_reg(REG_TEMP_CLOSE, 12'(400));
    write_reg(REG_CAP_OPEN, 12'(90));
    write_reg(REG_CAP_CLOSE, 12'(80));
    write_reg(REG_FAST_CAP, 12'(100));
    write_reg(REG_FAST_TEMP, 12'(1500));
    write_reg(REG_UNUSED, 12'hFFF);
    push_tick(250, 50, 1'b0, 1'b0);
    push_tick(250, 50, 1'b1, 1'b0);
    push_tick(250, 50, 1'b0, 1'b0);
    settle();

    // master off keeps the always cause until charging stops, then fast charge, game and temperature openings
    en = '0;
    en[EN_TEMP] = 1'b1;
    en[EN_CAP] = 1'b1;
    en[EN_FAST] = 1'b1;
    write_reg(REG_ENABLE, 12'(en));
    push_tick(1500, 100, 1'b1, 1'b1);
    push_tick(0, 50, 1'b0, 1'b0);
    push_tick(-400, 0, 1'b1, 1'b0);
    push_tick(-400, 0, 1'b1, 1'b1);
    push_tick(1500, 0, 1'b1, 1'b0);
    push_tick(2047, 127, 1'b1, 1'b0);
    settle();

    // temperature rule off clears a temperature cause; a capacity cause opens, closes, then reopens
    en[EN_TEMP] = 1'b0;
    write_reg(REG_ENABLE, 12'(en));
    push_tick(0, 127, 1'b1, 1'b0);
    push_tick(0, 0, 1'b1, 1'b0);
    push_tick(0, 100, 1'b1, 1'b0);
    settle();

    // capacity rule off clears a capacity cause; a temperature cause then opens and closes
    en[EN_TEMP] = 1'b1;
    en[EN_CAP] = 1'b0;
    write_reg(REG_ENABLE, 12'(en));
    write_reg(REG_FAST_CAP, 12'(0));
    write_reg(REG_FAST_TEMP, 12'(-400));
    push_tick(-2048, 100, 1'b1, 1'b0);
    push_tick(1499, 100, 1'b1, 1'b0);
    push_tick(399, 100, 1'b1, 1'b0);
    push_tick(400, 100, 1'b1, 1'b0);
    settle();

    en = 5'h1F;
    en[EN_ALWAYS] = 1'b0;
    write_reg(REG_ENABLE, 12'(en));
    write_reg(REG_TEMP_OPEN, 12'(-400));
    write_reg(REG_TEMP_CLOSE, 12'(-400));
    push_tick(-400, 0, 1'b1, 1'b0);
    push_tick(-400, 0, 1'b1, 1'b1);
    push_tick(-400, 0, 1'b0, 1'b0);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      en[EN_MASTER] = ($urandom_range(3) != 0);
      en[EN_ALWAYS] = ($urandom_range(3) == 0);
      en[EN_TEMP] = 1'($urandom_range(1));
      en[EN_CAP] = 1'($urandom_range(1));
      en[EN_FAST] = 1'($urandom_range(1));
      write_reg(REG_ENABLE, 12'(en));
      write_reg(REG_TEMP_OPEN, 12'(pick_temp()));
      write_reg(REG_TEMP_CLOSE, 12'(pick_temp()));
      write_reg(REG_CAP_OPEN, 12'(pick_cap()));
      write_reg(REG_CAP_CLOSE, 12'(pick_cap()));
      write_reg(REG_FAST_CAP, 12'(pick_cap()));
      write_reg(REG_FAST_TEMP, 12'(pick_temp()));
      case (ph % 4)
        0: begin gap_pct = 0; stall_pct = 0; end
        1: begin gap_pct = 52; stall_pct = 0; end
        2: begin gap_pct = 0; stall_pct = 52; end
        default: begin gap_pct = 21; stall_pct = 21; end
      endcase
      walk_temp = int'(t_open) + int'($urandom_range(200)) - 100;
      walk_cap = int'(c_open) + int'($urandom_range(20)) - 10;
      // two halves with a full drain between them
      for (int half = 0; half < 2; half++) begin
        if (ph == 0 && half == 0)
          hold_left = 100;
        for (int i = 0; i < HALF_TICKS; i++) begin
          if ($urandom_range(99) < 15) begin
            pending_ticks.push_back(tick_t'(21'($urandom)));
          end else begin
            walk_temp += int'($urandom_range(120)) - 60;
            walk_cap += int'($urandom_range(6)) - 3;
            if (walk_temp < -400) walk_temp = -400;
            if (walk_temp > 1500) walk_temp = 1500;
            if (walk_cap < 0) walk_cap = 0;
            if (walk_cap > 100) walk_cap = 100;
            if (game_on ? ($urandom_range(99) < 15) : ($urandom_range(99) < 3))
              game_on = !game_on;
            push_tick(walk_temp, walk_cap, $urandom_range(99) < 90, game_on);
          end
        end
        settle();
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("** charge_bypass_policy: PASSED **");
    else
      $display("** charge_bypass_policy: FAILED **");
    $finish;
  end

endmodule
